// ===== hdl/pms_pkg.sv =====
// Shared types, codes and constants for the power mode sequencer.
package pms_pkg;

	// Configuration register indexes and reset values.
	localparam int CFG_ADDR_W = 1;
	localparam int CFG_DATA_W = 6;
	localparam logic [CFG_ADDR_W-1:0] CFG_LONG_TIMEOUT  = 1'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_SHORT_TIMEOUT = 1'd1;
	localparam logic [CFG_DATA_W-1:0] LONG_TIMEOUT_RST  = 6'd40;
	localparam logic [CFG_DATA_W-1:0] SHORT_TIMEOUT_RST = 6'd1;

	// Stream widths.
	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 64;

	// Command codes.
	localparam logic [7:0] OP_CHARGE    = 8'h02;
	localparam logic [7:0] OP_DISCHARGE = 8'h03;
	localparam logic [7:0] OP_GVI       = 8'h04;
	localparam logic [7:0] OP_STOP      = 8'h05;
	localparam logic [7:0] OP_PROT_RST  = 8'h06;
	localparam logic [7:0] OP_STATUS    = 8'h0A;
	localparam logic [7:0] OP_SERIAL    = 8'h0F;

	// Frame lengths.
	localparam logic [7:0] LEN_CHARGE = 8'd2;
	localparam logic [7:0] LEN_OTHER  = 8'd1;

	// Reply headers.
	localparam logic [7:0] REPLY_NONE   = 8'h00;
	localparam logic [7:0] REPLY_CMD    = 8'h11;
	localparam logic [7:0] REPLY_STATUS = 8'h12;
	localparam logic [7:0] REPLY_SERIAL = 8'h1F;

	// Error codes.
	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_LEN   = 2'd1;
	localparam logic [1:0] ERR_MODE  = 2'd2;
	localparam logic [1:0] ERR_UNSUP = 2'd3;

	// Operating modes; a transition kind holds the mode left behind.
	localparam logic [1:0] MODE_STOP      = 2'd0;
	localparam logic [1:0] MODE_CHARGE    = 2'd1;
	localparam logic [1:0] MODE_GVI       = 2'd2;
	localparam logic [1:0] MODE_DISCHARGE = 2'd3;

	localparam logic [5:0] TICK_MAX = 6'd63;

	// Item kind carried in tuser.
	localparam logic KIND_CMD  = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	// One input item, last field in the lowest bits.
	typedef struct packed {
		logic       prot_bi;
		logic       prot_bz;
		logic       fb_btr;
		logic       fb_gvi;
		logic       fb_bz;
		logic [7:0] setup_byte;
		logic [7:0] frame_len;
		logic [7:0] opcode;
	} item_t;

	// Input item with its kind, as held in the input stage.
	typedef struct packed {
		logic  mode;
		item_t item;
	} in_word_t;

	// Output pin drives.
	typedef struct packed {
		logic       protect_reset_drive;
		logic       gvi_on_drive;
		logic       btr_select;
		logic       bz_off_drive;
		logic       bz_on_drive;
		logic [2:0] current_select;
		logic       charge_enable;
	} drives_t;

	// One result item, last field in the lowest bits.
	typedef struct packed {
		logic [15:0] unsupported_errors;
		logic [15:0] format_errors;
		drives_t     drives;
		logic [7:0]  status_byte;
		logic [7:0]  reply_code;
		logic [1:0]  error_code;
	} result_t;

	localparam drives_t DRIVES_RST = '{btr_select: 1'b1, current_select: 3'd0, default: 1'b0};

endpackage

// ===== hdl/pms_stage.sv =====
// Register slice holding one stream word, with full-rate handoff.
module pms_stage #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [W-1:0] in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] out_data
);
	logic         valid_q;
	logic [W-1:0] data_q;

	// Take a new word when empty or when the held word leaves this cycle.
	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// Payload needs no reset.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q <= in_data;
		end
	end
endmodule

// ===== hdl/pms_ctrl.sv =====
// Sequencer state, timeout registers and the per-item command and tick logic.
module pms_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [pms_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [pms_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                           fire,
	input  pms_pkg::in_word_t              word,
	output pms_pkg::result_t               result
);
	import pms_pkg::*;

	logic [5:0]  long_tmo_q, short_tmo_q;
	logic [1:0]  op_mode_q, kind_q;
	logic        timer_q, fault_q;
	logic [5:0]  tick_q;
	drives_t     drives_q;
	logic [15:0] fmt_cnt_q, unsup_cnt_q;

	logic [1:0]  op_mode_d, kind_d;
	logic        timer_d, fault_d;
	logic [5:0]  tick_d;
	drives_t     drives_d;
	logic [15:0] fmt_cnt_d, unsup_cnt_d;
	logic [1:0]  err;
	logic [7:0]  reply;

	// Tick watch terms.
	logic [5:0]  tick_inc;
	logic [5:0]  tmo;
	logic        watch_en, reached, rel_bz_on, rel_bz_off;
	logic        supported;
	logic [7:0]  need_len;
	item_t       it;

	assign it = word.item;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_tmo_q  <= LONG_TIMEOUT_RST;
			short_tmo_q <= SHORT_TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_LONG_TIMEOUT:  long_tmo_q  <= cfg_wdata;
				CFG_SHORT_TIMEOUT: short_tmo_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Which feedback pin the running timer watches, and its level.
	always_comb begin
		tick_inc   = (tick_q == TICK_MAX) ? tick_q : tick_q + 6'd1;
		watch_en   = 1'b1;
		reached    = 1'b0;
		tmo        = long_tmo_q;
		rel_bz_on  = 1'b0;
		rel_bz_off = 1'b0;
		unique case (kind_q)
			MODE_STOP: begin
				unique case (op_mode_q)
					MODE_CHARGE: begin
						reached   = !it.fb_bz;
						rel_bz_on = 1'b1;
					end
					MODE_GVI:       reached = !it.fb_gvi;
					MODE_DISCHARGE: begin
						reached = it.fb_btr;
						tmo     = short_tmo_q;
					end
					default:        watch_en = 1'b0;
				endcase
			end
			MODE_CHARGE: begin
				reached    = it.fb_bz;
				rel_bz_off = 1'b1;
			end
			MODE_GVI: reached = it.fb_gvi;
			default: begin
				reached = !it.fb_btr;
				tmo     = short_tmo_q;
			end
		endcase
	end

	// Opcode decode and length check.
	always_comb begin
		supported = (it.opcode == OP_CHARGE) || (it.opcode == OP_DISCHARGE) ||
		            (it.opcode == OP_GVI) || (it.opcode == OP_STOP) ||
		            (it.opcode == OP_PROT_RST) || (it.opcode == OP_STATUS) ||
		            (it.opcode == OP_SERIAL);
		need_len  = (it.opcode == OP_CHARGE) ? LEN_CHARGE : LEN_OTHER;
	end

	// Next state and result for the item in the input stage.
	always_comb begin
		op_mode_d   = op_mode_q;
		kind_d      = kind_q;
		timer_d     = timer_q;
		fault_d     = fault_q;
		tick_d      = tick_q;
		drives_d    = drives_q;
		fmt_cnt_d   = fmt_cnt_q;
		unsup_cnt_d = unsup_cnt_q;
		err         = ERR_NONE;
		reply       = REPLY_NONE;

		if (word.mode == KIND_TICK) begin
			if (timer_q) begin
				tick_d = tick_inc;
				if (watch_en && (reached || tick_inc >= tmo)) begin
					if (!reached) begin
						fault_d = 1'b1;
					end
					if (rel_bz_on) begin
						drives_d.bz_on_drive = 1'b0;
					end
					if (rel_bz_off) begin
						drives_d.bz_off_drive = 1'b0;
					end
					timer_d = 1'b0;
					tick_d  = '0;
				end
			end
		end else if (!supported) begin
			unsup_cnt_d = unsup_cnt_q + 16'd1;
			err         = ERR_UNSUP;
		end else if (it.frame_len != need_len) begin
			fmt_cnt_d = fmt_cnt_q + 16'd1;
			err       = ERR_LEN;
		end else begin
			unique case (it.opcode)
				OP_CHARGE, OP_DISCHARGE, OP_GVI: begin
					if (op_mode_q != MODE_STOP) begin
						err = ERR_MODE;
					end else begin
						kind_d  = op_mode_q;
						timer_d = 1'b1;
						tick_d  = '0;
						reply   = REPLY_CMD;
						if (it.opcode == OP_CHARGE) begin
							drives_d.charge_enable  = it.setup_byte[0];
							drives_d.current_select = it.setup_byte[4:2];
							drives_d.bz_on_drive    = 1'b1;
							op_mode_d               = MODE_CHARGE;
						end else if (it.opcode == OP_DISCHARGE) begin
							drives_d.btr_select = 1'b0;
							op_mode_d           = MODE_DISCHARGE;
						end else begin
							drives_d.gvi_on_drive = 1'b1;
							op_mode_d             = MODE_GVI;
						end
					end
				end
				OP_STOP: begin
					if (op_mode_q == MODE_STOP) begin
						err = ERR_MODE;
					end else begin
						unique case (op_mode_q)
							MODE_CHARGE: begin
								drives_d.charge_enable = 1'b0;
								drives_d.bz_off_drive  = 1'b1;
							end
							MODE_GVI: drives_d.gvi_on_drive = 1'b0;
							default:  drives_d.btr_select   = 1'b1;
						endcase
						kind_d    = op_mode_q;
						timer_d   = 1'b1;
						tick_d    = '0;
						op_mode_d = MODE_STOP;
						reply     = REPLY_CMD;
					end
				end
				OP_PROT_RST: begin
					drives_d.protect_reset_drive = 1'b1;
					reply                        = REPLY_CMD;
				end
				OP_STATUS: reply = REPLY_STATUS;
				default:   reply = REPLY_SERIAL;
			endcase
		end
	end

	// Result reflects the state after this item.
	always_comb begin
		result.error_code         = err;
		result.reply_code         = reply;
		result.status_byte        = {1'b0, !fault_d, it.prot_bi, it.prot_bz, 1'b0,
		                             it.fb_btr, it.fb_gvi, it.fb_bz};
		result.drives             = drives_d;
		result.format_errors      = fmt_cnt_d;
		result.unsupported_errors = unsup_cnt_d;
	end

	// State update when the item moves into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_mode_q   <= MODE_STOP;
			kind_q      <= MODE_STOP;
			timer_q     <= 1'b0;
			fault_q     <= 1'b0;
			tick_q      <= '0;
			drives_q    <= DRIVES_RST;
			fmt_cnt_q   <= '0;
			unsup_cnt_q <= '0;
		end else if (fire) begin
			op_mode_q   <= op_mode_d;
			kind_q      <= kind_d;
			timer_q     <= timer_d;
			fault_q     <= fault_d;
			tick_q      <= tick_d;
			drives_q    <= drives_d;
			fmt_cnt_q   <= fmt_cnt_d;
			unsup_cnt_q <= unsup_cnt_d;
		end
	end
endmodule

// ===== hdl/power_mode_sequencer_core.sv =====
// Top level of the power mode sequencer: input stage, sequencer logic, result stage.
//
//   channel  | direction | handshake         | payload
//   s_       | in        | s_tvalid/s_tready | s_tdata items, s_tuser item kind
//   m_       | out       | m_tvalid/m_tready | m_tdata results
//   cfg_     | in        | cfg_we            | cfg_addr, cfg_wdata
//
// One item per cycle sustained while m_ is not stalled; each result passes through the
// input stage register and then the result register before it is on m_.
// All work runs between the input stage register and the result register.
// Reset clears the sequencer state and loads the default timeouts.
// A stall on m_ holds the result; the input stage keeps one more item,
// then s_tready drops until the result is taken.
module power_mode_sequencer_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [7:0] opcode, [15:8] frame_len, [23:16] setup_byte, [24] fb_bz, [25] fb_gvi,
	// [26] fb_btr, [27] prot_bz, [28] prot_bi, [31:29] zero
	input  logic [pms_pkg::S_TDATA_W-1:0]  s_tdata,
	// [0] mode
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [1:0] error_code, [9:2] reply_code, [17:10] status_byte, [18] charge_enable,
	// [21:19] current_select, [22] bz_on_drive, [23] bz_off_drive, [24] btr_select,
	// [25] gvi_on_drive, [26] protect_reset_drive, [42:27] format_errors,
	// [58:43] unsupported_errors, [63:59] zero
	output logic [pms_pkg::M_TDATA_W-1:0]  m_tdata,
	input  logic                           cfg_we,
	input  logic [pms_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [pms_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import pms_pkg::*;

	in_word_t in_word, word_s1;
	logic     valid_s1, adv_s1;
	result_t  result, result_s2;

	assign in_word.mode = s_tuser;
	assign in_word.item = s_tdata[$bits(item_t)-1:0];

	pms_stage #(.W($bits(in_word_t))) u_in_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (in_word),
		.out_valid (valid_s1),
		.out_ready (adv_s1),
		.out_data  (word_s1)
	);

	logic res_ready;
	assign adv_s1 = res_ready;

	pms_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.fire      (valid_s1 && res_ready),
		.word      (word_s1),
		.result    (result)
	);

	pms_stage #(.W($bits(result_t))) u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_ready  (res_ready),
		.in_data   (result),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (result_s2)
	);

	assign m_tdata = {{(M_TDATA_W - $bits(result_t)){1'b0}}, result_s2};
endmodule

// ===== hdl/pms_checker.sv =====
// Port-level checks for the power mode sequencer and their binding.
module pms_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [pms_pkg::M_TDATA_W-1:0] m_tdata
);
	import pms_pkg::*;

	result_t res;
	logic    out_xfer;
	logic    fault_seen_q;
	logic    prot_seen_q;

	assign res      = m_tdata[$bits(result_t)-1:0];
	assign out_xfer = m_tvalid && m_tready;

	// Remember a reported fault and a raised protection reset drive.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fault_seen_q <= 1'b0;
			prot_seen_q  <= 1'b0;
		end else if (out_xfer) begin
			fault_seen_q <= fault_seen_q || !res.status_byte[6];
			prot_seen_q  <= prot_seen_q || res.drives.protect_reset_drive;
		end
	end

	// A stalled result stays put.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// An error never carries a reply header.
	a_err_reply: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.error_code != ERR_NONE |-> res.reply_code == REPLY_NONE)
		else $error("reply header on an error result");

	// Once reported, a fault stays reported.
	a_fault_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && fault_seen_q |-> !res.status_byte[6])
		else $error("fault flag cleared");

	// The protection reset drive never drops once raised.
	a_prot_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && prot_seen_q |-> res.drives.protect_reset_drive)
		else $error("protection reset drive dropped");
endmodule

bind power_mode_sequencer_core pms_checker u_pms_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== bench/pms_result_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the power mode sequencer: predicts each result and compares it.
module pms_result_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [pms_pkg::S_TDATA_W-1:0]   s_tdata,
	input  logic                            s_tuser,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [pms_pkg::M_TDATA_W-1:0]   m_tdata,
	input  logic                            cfg_we,
	input  logic [pms_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [pms_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output int                              mismatches,
	output int                              pending
);
	import pms_pkg::*;

	// Predicted sequencer state and timeout settings.
	logic [1:0]  op_mode;
	logic [1:0]  watch_kind;
	logic        timer_on;
	logic [5:0]  tick_cnt;
	logic        fault_seen;
	drives_t     drv;
	logic [15:0] fmt_cnt;
	logic [15:0] unsup_cnt;
	logic [CFG_DATA_W-1:0] long_to;
	logic [CFG_DATA_W-1:0] short_to;

	// Results still owed by the block, oldest first.
	result_t     expected_results [$];
	result_t     want;
	result_t     got;
	item_t       in_item;

	initial begin
		mismatches = 0;
		pending = 0;
	end

	// Start a confirmation timer; the mode being left decides what is watched.
	function automatic void arm_timer();
		watch_kind = op_mode;
		timer_on = 1'b1;
		tick_cnt = '0;
	endfunction

	// Ends the watch on success or timeout; a timeout leaves a sticky fault.
	function automatic logic watch_done(input logic reached, input logic [5:0] limit);
		if (reached || tick_cnt >= limit) begin
			if (!reached)
				fault_seen = 1'b1;
			timer_on = 1'b0;
			tick_cnt = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// A timer tick advances the running watch, if any.
	function automatic void run_tick(input item_t it);
		if (!timer_on)
			return;
		if (tick_cnt != TICK_MAX)
			tick_cnt = tick_cnt + 1'b1;
		case (watch_kind)
			MODE_STOP: begin
				case (op_mode)
					MODE_CHARGE: begin
						if (watch_done(!it.fb_bz, long_to))
							drv.bz_on_drive = 1'b0;
					end
					MODE_GVI:       void'(watch_done(!it.fb_gvi, long_to));
					MODE_DISCHARGE: void'(watch_done(it.fb_btr, short_to));
					default: ;
				endcase
			end
			MODE_CHARGE: begin
				if (watch_done(it.fb_bz, long_to))
					drv.bz_off_drive = 1'b0;
			end
			MODE_GVI: void'(watch_done(it.fb_gvi, long_to));
			default:  void'(watch_done(!it.fb_btr, short_to));
		endcase
	endfunction

	// Decode one command frame; returns the error code and sets the reply header.
	function automatic logic [1:0] run_command(input item_t it, output logic [7:0] reply);
		logic [7:0] need;
		need = (it.opcode == OP_CHARGE) ? LEN_CHARGE : LEN_OTHER;
		reply = REPLY_NONE;
		case (it.opcode)
			OP_CHARGE, OP_DISCHARGE, OP_GVI, OP_STOP, OP_PROT_RST, OP_STATUS, OP_SERIAL: ;
			default: begin
				unsup_cnt = unsup_cnt + 1'b1;
				return ERR_UNSUP;
			end
		endcase
		// Length is checked before the mode.
		if (it.frame_len != need) begin
			fmt_cnt = fmt_cnt + 1'b1;
			return ERR_LEN;
		end
		case (it.opcode)
			OP_CHARGE: begin
				if (op_mode != MODE_STOP)
					return ERR_MODE;
				drv.charge_enable = it.setup_byte[0];
				drv.current_select = it.setup_byte[4:2];
				drv.bz_on_drive = 1'b1;
				arm_timer();
				op_mode = MODE_CHARGE;
				reply = REPLY_CMD;
			end
			OP_DISCHARGE: begin
				if (op_mode != MODE_STOP)
					return ERR_MODE;
				drv.btr_select = 1'b0;
				arm_timer();
				op_mode = MODE_DISCHARGE;
				reply = REPLY_CMD;
			end
			OP_GVI: begin
				if (op_mode != MODE_STOP)
					return ERR_MODE;
				drv.gvi_on_drive = 1'b1;
				arm_timer();
				op_mode = MODE_GVI;
				reply = REPLY_CMD;
			end
			OP_STOP: begin
				case (op_mode)
					MODE_CHARGE: begin
						drv.charge_enable = 1'b0;
						drv.bz_off_drive = 1'b1;
					end
					MODE_GVI:       drv.gvi_on_drive = 1'b0;
					MODE_DISCHARGE: drv.btr_select = 1'b1;
					default:        return ERR_MODE;
				endcase
				arm_timer();
				op_mode = MODE_STOP;
				reply = REPLY_CMD;
			end
			OP_PROT_RST: begin
				drv.protect_reset_drive = 1'b1;
				reply = REPLY_CMD;
			end
			OP_STATUS: reply = REPLY_STATUS;
			default:   reply = REPLY_SERIAL;
		endcase
		return ERR_NONE;
	endfunction

	// Apply one input item to the predicted state and build its result.
	function automatic result_t predict_result(input logic kind, input item_t it);
		result_t    r;
		logic [1:0] err;
		logic [7:0] reply;
		err = ERR_NONE;
		reply = REPLY_NONE;
		if (kind == KIND_TICK)
			run_tick(it);
		else
			err = run_command(it, reply);
		r.error_code = err;
		r.reply_code = (err == ERR_NONE) ? reply : REPLY_NONE;
		r.status_byte = {1'b0, !fault_seen, it.prot_bi, it.prot_bz, 1'b0,
			it.fb_btr, it.fb_gvi, it.fb_bz};
		r.drives = drv;
		r.format_errors = fmt_cnt;
		r.unsupported_errors = unsup_cnt;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [15:0] exp_v,
		input logic [15:0] act_v);
		if (exp_v !== act_v) begin
			mismatches = mismatches + 1;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
		end
	endfunction

	// Watch both channels and the register port at every rising edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_mode = MODE_STOP;
			watch_kind = MODE_STOP;
			timer_on = 1'b0;
			tick_cnt = '0;
			fault_seen = 1'b0;
			drv = DRIVES_RST;
			fmt_cnt = '0;
			unsup_cnt = '0;
			long_to = LONG_TIMEOUT_RST;
			short_to = SHORT_TIMEOUT_RST;
			expected_results.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					CFG_LONG_TIMEOUT:  long_to = cfg_wdata;
					CFG_SHORT_TIMEOUT: short_to = cfg_wdata;
					default: ;
				endcase
			end
			// Result transfer: compare against the oldest prediction.
			if (m_tvalid && m_tready) begin
				got = m_tdata[$bits(result_t)-1:0];
				if (expected_results.size() == 0) begin
					mismatches = mismatches + 1;
					$display("%0t: result %h, expected none", $time, m_tdata);
				end else begin
					want = expected_results.pop_front();
					check_field("error_code", want.error_code, got.error_code);
					check_field("reply_code", want.reply_code, got.reply_code);
					check_field("status_byte", want.status_byte, got.status_byte);
					check_field("charge_enable", want.drives.charge_enable,
						got.drives.charge_enable);
					check_field("current_select", want.drives.current_select,
						got.drives.current_select);
					check_field("bz_on_drive", want.drives.bz_on_drive,
						got.drives.bz_on_drive);
					check_field("bz_off_drive", want.drives.bz_off_drive,
						got.drives.bz_off_drive);
					check_field("btr_select", want.drives.btr_select, got.drives.btr_select);
					check_field("gvi_on_drive", want.drives.gvi_on_drive,
						got.drives.gvi_on_drive);
					check_field("protect_reset_drive", want.drives.protect_reset_drive,
						got.drives.protect_reset_drive);
					check_field("format_errors", want.format_errors, got.format_errors);
					check_field("unsupported_errors", want.unsupported_errors,
						got.unsupported_errors);
					check_field("padding", '0, m_tdata[M_TDATA_W-1:$bits(result_t)]);
				end
			end
			// Item transfer: predict its result.
			if (s_tvalid && s_tready) begin
				in_item = s_tdata[$bits(item_t)-1:0];
				expected_results.push_back(predict_result(s_tuser, in_item));
			end
		end
		pending = expected_results.size();
	end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Top of the power mode sequencer testbench: clock, reset, stimulus and verdict.
module testbench;
	import pms_pkg::*;

	localparam int HOLD_CYCLES   = 300;
	localparam int DRAIN_CYCLES  = 4;
	localparam int PHASE_ITEMS   = 200;
	localparam int PHASES        = 6;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	int                    mismatches;
	int                    pending;

	// Idle rates in percent, and the request for one long receiver hold-off.
	int                    send_idle_pct;
	int                    stall_pct;
	logic                  hold_req;
	logic [2:0]            fb_level;

	always #1 clk = ~clk;

	power_mode_sequencer_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	pms_result_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// Present one item at the falling edge and hold it until its transfer.
	task automatic send_item(input logic kind, input item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {{(S_TDATA_W - $bits(item_t)){1'b0}}, it};
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	// Command frame with random feedback and protection pins.
	task automatic send_cmd(input logic [7:0] opc, input logic [7:0] len,
		input logic [7:0] setup);
		logic [4:0] pins;
		pins = 5'($urandom_range(31));
		send_item(KIND_CMD, {pins, setup, len, opc});
	endtask

	// Timer tick; fb holds fb_btr, fb_gvi, fb_bz from the top bit down.
	task automatic send_tick(input logic [2:0] fb);
		logic [1:0] prot;
		prot = 2'($urandom_range(3));
		send_item(KIND_TICK, {prot, fb, 8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255))});
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
		input logic [CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Wait until every predicted result has been taken, then let the pipeline settle.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic logic [7:0] pick_opcode();
		case ($urandom_range(6))
			0:       return OP_CHARGE;
			1:       return OP_DISCHARGE;
			2:       return OP_GVI;
			3:       return OP_STOP;
			4:       return OP_PROT_RST;
			5:       return OP_STATUS;
			default: return OP_SERIAL;
		endcase
	endfunction

	// Mostly well-formed commands and ticks; feedback pins stay put for long runs
	// so that both confirmations and timeouts occur.
	task automatic send_random_item();
		int         roll;
		logic [2:0] fb;
		logic [1:0] prot;
		logic [7:0] opc;
		logic [7:0] len;
		logic [7:0] setup;
		roll = $urandom_range(99);
		if ($urandom_range(31) == 0)
			fb_level = 3'($urandom_range(7));
		fb = fb_level;
		if ($urandom_range(9) == 0)
			fb = fb ^ 3'($urandom_range(7));
		prot = 2'($urandom_range(3));
		opc = pick_opcode();
		len = (opc == OP_CHARGE) ? LEN_CHARGE : LEN_OTHER;
		setup = 8'($urandom_range(255));
		if (roll >= 95) begin
			opc = 8'($urandom_range(255));
			len = 8'($urandom_range(255));
		end else if (roll >= 85) begin
			len = 8'($urandom_range(255));
		end
		send_item((roll < 45) ? KIND_TICK : KIND_CMD, {prot, fb, setup, len, opc});
	endtask

	// Receiver: random stalls, plus one long hold-off counted here.
	initial begin
		logic hold_taken;
		hold_taken = 1'b0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Stimulus and verdict.
	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = KIND_CMD;
		cfg_we = 1'b0;
		cfg_addr = CFG_LONG_TIMEOUT;
		cfg_wdata = '0;
		send_idle_pct = 0;
		stall_pct = 0;
		hold_req = 1'b0;
		fb_level = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: error cases first, then each transition; the discharge start times out, the others are confirmed.
		send_tick(3'b000);
		send_cmd(OP_STOP, LEN_OTHER, '0);
		send_cmd('0, LEN_OTHER, '0);
		send_cmd('1, '1, '1);
		send_cmd(OP_CHARGE, LEN_OTHER, '1);
		send_cmd(OP_STATUS, '0, '0);
		send_cmd(OP_SERIAL, '1, '0);
		send_cmd(OP_STATUS, LEN_OTHER, '0);
		send_cmd(OP_SERIAL, LEN_OTHER, '0);
		send_cmd(OP_PROT_RST, LEN_OTHER, '0);
		send_cmd(OP_CHARGE, LEN_CHARGE, '1);
		send_cmd(OP_GVI, LEN_OTHER, '0);
		send_tick(3'b001);
		send_tick(3'b000);
		send_cmd(OP_STOP, LEN_OTHER, '0);
		send_tick(3'b000);
		send_tick(3'b001);
		send_cmd(OP_GVI, LEN_OTHER, '0);
		send_tick(3'b010);
		send_tick(3'b000);
		send_cmd(OP_STOP, LEN_OTHER, '0);
		send_tick(3'b010);
		send_cmd(OP_DISCHARGE, LEN_OTHER, '0);
		send_tick(3'b000);
		send_cmd(OP_STOP, LEN_OTHER, '0);
		send_tick(3'b000);

		// Random phases; all but the first write new timeouts, and the idle pattern rotates among four settings.
		for (int p = 0; p < PHASES; p++) begin
			wait_idle();
			case (p)
				1: begin
					write_reg(CFG_LONG_TIMEOUT, 6'd1);
					write_reg(CFG_SHORT_TIMEOUT, 6'd63);
				end
				2: begin
					write_reg(CFG_LONG_TIMEOUT, 6'd63);
					write_reg(CFG_SHORT_TIMEOUT, 6'd1);
				end
				3: begin
					write_reg(CFG_LONG_TIMEOUT, 6'd0);
					write_reg(CFG_SHORT_TIMEOUT, 6'd0);
				end
				4: begin
					write_reg(CFG_LONG_TIMEOUT, 6'($urandom_range(63)));
					write_reg(CFG_SHORT_TIMEOUT, 6'($urandom_range(63)));
				end
				5: begin
					write_reg(CFG_LONG_TIMEOUT, 6'd63);
					write_reg(CFG_SHORT_TIMEOUT, 6'd63);
				end
				default: ;
			endcase
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 85;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 85;
				end
				default: begin
					send_idle_pct = 26;
					stall_pct = 26;
				end
			endcase
			// The sender keeps offering items while the receiver holds off.
			if (p == 0)
				hold_req = 1'b1;
			repeat (PHASE_ITEMS) send_random_item();
		end

		wait_idle();
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#200000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
